// File: rtl/core/wsfd_pkg.sv
// Shared types and constants of the WebSocket frame decoder.
package wsfd_pkg;

  localparam logic [3:0] OpText    = 4'h1;
  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;
  localparam logic [2:0] Ext16Cnt  = 3'd1;
  localparam logic [2:0] Ext64Cnt  = 3'd7;
  localparam logic [2:0] KeyCnt    = 3'd3;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4,
    PH_SKIP = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_buffer;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic       end_of_message;
    logic       aborted;
  } result_t;

  // Command from the parser to the output stage.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic       has_byte;
    logic       end_of_message;
    logic       aborted;
  } cmd_t;

endpackage

// File: rtl/core/wsfd_stream_if.sv
// Valid/ready stream channel with a typed payload.
interface wsfd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/wsfd_front.sv
// Frame header parser: classifies each received byte and issues output commands.
module wsfd_front import wsfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  rx_item_t   item_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        mask_q, mask_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  kidx_q, kidx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR0;
      hdr_cnt_q <= '0;
      opcode_q  <= '0;
      mask_q    <= 1'b0;
      rem_q     <= '0;
      key_q     <= '0;
      kidx_q    <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      opcode_q  <= opcode_d;
      mask_q    <= mask_d;
      rem_q     <= rem_d;
      key_q     <= key_d;
      kidx_q    <= kidx_d;
    end
  end

  logic [7:0] b;
  logic       len_fin;
  logic       hdr_fin;
  logic       emit;
  logic [7:0] key_byte;

  assign b = item_i.rx_byte;

  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    opcode_d  = opcode_q;
    mask_d    = mask_q;
    rem_d     = rem_q;
    key_d     = key_q;
    kidx_d    = kidx_q;
    len_fin   = 1'b0;
    hdr_fin   = 1'b0;
    emit      = 1'b0;
    cmd_o     = '0;
    unique case (kidx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase

    unique case (phase_q)
      PH_HDR1: begin
        mask_d = b[7];
        rem_d  = '0;
        if (b[6:0] == Len16Code) begin
          phase_d   = PH_EXT;
          hdr_cnt_d = Ext16Cnt;
        end else if (b[6:0] == Len64Code) begin
          phase_d   = PH_EXT;
          hdr_cnt_d = Ext64Cnt;
        end else begin
          rem_d   = {57'd0, b[6:0]};
          len_fin = 1'b1;
        end
      end
      PH_EXT: begin
        rem_d = {rem_q[55:0], b};
        if (hdr_cnt_q == 3'd0) len_fin = 1'b1;
        else hdr_cnt_d = hdr_cnt_q - 3'd1;
      end
      PH_KEY: begin
        key_d = {key_q[23:0], b};
        if (hdr_cnt_q == 3'd0) hdr_fin = 1'b1;
        else hdr_cnt_d = hdr_cnt_q - 3'd1;
      end
      PH_DATA: begin
        kidx_d = kidx_q + 2'd1;
        rem_d  = rem_q - 64'd1;
        if (rem_d == 64'd0) phase_d = PH_SKIP;
        if (opcode_q == OpText) begin
          emit                 = 1'b1;
          cmd_o.data           = b;
          cmd_o.key            = mask_q ? key_byte : 8'd0;
          cmd_o.has_byte       = 1'b1;
          cmd_o.end_of_message = (rem_d == 64'd0);
        end
      end
      PH_SKIP: begin
      end
      default: begin
        opcode_d  = b[3:0];
        mask_d    = 1'b0;
        rem_d     = '0;
        key_d     = '0;
        kidx_d    = '0;
        hdr_cnt_d = '0;
        phase_d   = PH_HDR1;
      end
    endcase

    // Length known: read the key next or close the header.
    if (len_fin) begin
      if (mask_d) begin
        phase_d   = PH_KEY;
        hdr_cnt_d = KeyCnt;
      end else begin
        hdr_fin = 1'b1;
      end
    end

    if (hdr_fin) begin
      kidx_d = '0;
      if (rem_d == 64'd0) begin
        phase_d = PH_SKIP;
        if (opcode_q == OpText) begin
          emit                 = 1'b1;
          cmd_o.end_of_message = 1'b1;
        end
      end else begin
        phase_d = PH_DATA;
      end
    end

    // Buffer ended mid-frame: replace any result with an abort.
    if (item_i.end_of_buffer) begin
      if (phase_d != PH_SKIP && phase_d != PH_HDR0) begin
        emit          = 1'b1;
        cmd_o         = '0;
        cmd_o.aborted = 1'b1;
      end
      phase_d = PH_HDR0;
    end
  end

  assign push_o = accept_i && emit;

endmodule

// File: rtl/core/wsfd_cmd_fifo.sv
// Short command queue between the parser and the output stage.
module wsfd_cmd_fifo import wsfd_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      if (do_pop)  rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

// File: rtl/core/wsfd_back.sv
// Output stage: unmasks payload bytes and holds the result word for the consumer.
module wsfd_back import wsfd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  avail_i,
  input  cmd_t                  cmd_i,
  output logic                  pop_o,
  wsfd_stream_if.source         res_o
);

  logic    valid_q;
  result_t res_q, res_d;

  assign pop_o = avail_i && (!valid_q || res_o.ready);

  always_comb begin
    res_d.payload_byte   = cmd_i.data ^ cmd_i.key;
    res_d.has_byte       = cmd_i.has_byte;
    res_d.end_of_message = cmd_i.end_of_message;
    res_d.aborted        = cmd_i.aborted;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) res_q <= res_d;
  end

  assign res_o.valid   = valid_q;
  assign res_o.payload = res_q;

endmodule

// File: rtl/core/websocket_frame_decoder_unit.sv
// WebSocket frame decoder: one received byte per cycle, one text payload word per byte.
// Each result word passes through the command queue and then the output register.
// Throughput: one byte per cycle while the queue has room, set by the parser update.
// The input stalls only when the command queue is full behind a stalled output.
// Reset (async, active low) returns the parser to the first header byte, empties the queue.
module websocket_frame_decoder_unit import wsfd_pkg::*; #(
  parameter int unsigned FifoDepth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  wsfd_stream_if.sink   rx_i,
  wsfd_stream_if.source res_o
);

  logic accept;
  logic push;
  logic full;
  logic empty;
  logic pop;
  cmd_t cmd_in;
  cmd_t cmd_out;

  assign rx_i.ready = !full;
  assign accept     = rx_i.valid && !full;

  wsfd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (rx_i.payload),
    .push_o   (push),
    .cmd_o    (cmd_in)
  );

  wsfd_cmd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (cmd_out),
    .empty_o (empty)
  );

  wsfd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (!empty),
    .cmd_i   (cmd_out),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule
